// ===== rtl/fmbq_pkg.sv =====
// Shared constants, codes and controller/datapath interface types of the queue.
package fmbq_pkg;

    localparam int DEPTH      = 1024;
    localparam int DATA_WIDTH = 32;
    localparam int PTR_W      = $clog2(DEPTH);
    localparam int CNT_W      = $clog2(DEPTH + 1);
    localparam int RAM_DEPTH  = 2 * (1 << PTR_W);
    localparam int RAM_AW     = PTR_W + 1;
    localparam int ACTION_W   = 3;
    localparam int VALUE_W    = 32;
    localparam int DATA_W     = 32;
    localparam int STATUS_W   = 2;
    localparam int OCC_W      = 11;
    localparam int S_TDATA_W  = 40;
    localparam int M_TDATA_W  = 48;

    localparam logic [ACTION_W-1:0] ACT_PUSH_FRONT  = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_PUSH_MIDDLE = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_PUSH_BACK   = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_POP_FRONT   = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_POP_MIDDLE  = 3'd4;
    localparam logic [ACTION_W-1:0] ACT_POP_BACK    = 3'd5;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    // Which half-deque and which of its ends.
    localparam logic HALF_FRONT = 1'b0;
    localparam logic HALF_BACK  = 1'b1;
    localparam logic END_HEAD   = 1'b0;
    localparam logic END_TAIL   = 1'b1;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_EXEC = 6'b000010,
        S_POPW = 6'b000100,
        S_BAL  = 6'b001000,
        S_MOVW = 6'b010000,
        S_FIN  = 6'b100000
    } state_t;

    typedef struct packed {
        logic                accept;
        logic                push;
        logic                pop;
        logic                half;
        logic                tail;
        logic                from_ram;
        logic                cap_data;
        logic                set_status;
        logic [STATUS_W-1:0] status;
        logic                load_out;
    } dp_cmd_t;

    typedef struct packed {
        logic empty;
        logic full;
        logic odd;
        logic front_empty;
        logic b2f;
        logic f2b;
        logic out_busy;
    } dp_stat_t;

endpackage

// ===== rtl/fmbq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module fmbq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== rtl/fmbq_ctrl.sv =====
// Operation sequencer: decides the half-deque accesses and the rebalancing move.
module fmbq_ctrl (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [fmbq_pkg::ACTION_W-1:0]  in_action,
    input  fmbq_pkg::dp_stat_t             stat,
    output fmbq_pkg::dp_cmd_t              cmd
);

    fmbq_pkg::state_t               state_reg, state_next;
    logic [fmbq_pkg::ACTION_W-1:0]  action_reg, action_next;
    logic                           mv_b2f_reg, mv_b2f_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= fmbq_pkg::S_IDLE;
        end else begin
            state_reg <= state_next;
        end
        action_reg <= action_next;
        mv_b2f_reg <= mv_b2f_next;
    end

    assign s_tready = (state_reg == fmbq_pkg::S_IDLE);

    always_comb begin
        state_next  = state_reg;
        action_next = action_reg;
        mv_b2f_next = mv_b2f_reg;
        cmd         = '0;
        case (state_reg)
            fmbq_pkg::S_IDLE: begin
                if (s_tvalid) begin
                    cmd.accept  = 1'b1;
                    action_next = in_action;
                    state_next  = fmbq_pkg::S_EXEC;
                end
            end
            fmbq_pkg::S_EXEC: begin
                state_next = fmbq_pkg::S_FIN;
                case (action_reg)
                    fmbq_pkg::ACT_PUSH_FRONT, fmbq_pkg::ACT_PUSH_MIDDLE,
                    fmbq_pkg::ACT_PUSH_BACK: begin
                        if (stat.full) begin
                            cmd.set_status = 1'b1;
                            cmd.status     = fmbq_pkg::ST_FULL;
                        end else begin
                            cmd.push   = 1'b1;
                            state_next = fmbq_pkg::S_BAL;
                            if (action_reg == fmbq_pkg::ACT_PUSH_FRONT) begin
                                cmd.half = fmbq_pkg::HALF_FRONT;
                                cmd.tail = fmbq_pkg::END_HEAD;
                            end else if (action_reg == fmbq_pkg::ACT_PUSH_BACK) begin
                                cmd.half = fmbq_pkg::HALF_BACK;
                                cmd.tail = fmbq_pkg::END_TAIL;
                            end else if (stat.odd) begin
                                cmd.half = fmbq_pkg::HALF_FRONT;
                                cmd.tail = fmbq_pkg::END_TAIL;
                            end else begin
                                cmd.half = fmbq_pkg::HALF_BACK;
                                cmd.tail = fmbq_pkg::END_HEAD;
                            end
                        end
                    end
                    fmbq_pkg::ACT_POP_FRONT, fmbq_pkg::ACT_POP_MIDDLE,
                    fmbq_pkg::ACT_POP_BACK: begin
                        if (stat.empty) begin
                            cmd.set_status = 1'b1;
                            cmd.status     = fmbq_pkg::ST_EMPTY;
                        end else begin
                            cmd.pop    = 1'b1;
                            state_next = fmbq_pkg::S_POPW;
                            if (action_reg == fmbq_pkg::ACT_POP_FRONT) begin
                                // A single stored word always sits in the back half.
                                cmd.half = stat.front_empty ? fmbq_pkg::HALF_BACK
                                                            : fmbq_pkg::HALF_FRONT;
                                cmd.tail = fmbq_pkg::END_HEAD;
                            end else if (action_reg == fmbq_pkg::ACT_POP_BACK) begin
                                cmd.half = fmbq_pkg::HALF_BACK;
                                cmd.tail = fmbq_pkg::END_TAIL;
                            end else if (stat.odd) begin
                                cmd.half = fmbq_pkg::HALF_BACK;
                                cmd.tail = fmbq_pkg::END_HEAD;
                            end else begin
                                cmd.half = fmbq_pkg::HALF_FRONT;
                                cmd.tail = fmbq_pkg::END_TAIL;
                            end
                        end
                    end
                    default: begin
                        state_next = fmbq_pkg::S_FIN;
                    end
                endcase
            end
            fmbq_pkg::S_POPW: begin
                cmd.cap_data = 1'b1;
                state_next   = fmbq_pkg::S_BAL;
            end
            fmbq_pkg::S_BAL: begin
                // The back half holds as many words as the front half or one more.
                if (stat.b2f) begin
                    cmd.pop     = 1'b1;
                    cmd.half    = fmbq_pkg::HALF_BACK;
                    cmd.tail    = fmbq_pkg::END_HEAD;
                    mv_b2f_next = 1'b1;
                    state_next  = fmbq_pkg::S_MOVW;
                end else if (stat.f2b) begin
                    cmd.pop     = 1'b1;
                    cmd.half    = fmbq_pkg::HALF_FRONT;
                    cmd.tail    = fmbq_pkg::END_TAIL;
                    mv_b2f_next = 1'b0;
                    state_next  = fmbq_pkg::S_MOVW;
                end else begin
                    state_next = fmbq_pkg::S_FIN;
                end
            end
            fmbq_pkg::S_MOVW: begin
                cmd.push     = 1'b1;
                cmd.from_ram = 1'b1;
                cmd.half     = mv_b2f_reg ? fmbq_pkg::HALF_FRONT : fmbq_pkg::HALF_BACK;
                cmd.tail     = mv_b2f_reg ? fmbq_pkg::END_TAIL : fmbq_pkg::END_HEAD;
                state_next   = fmbq_pkg::S_FIN;
            end
            fmbq_pkg::S_FIN: begin
                if (!stat.out_busy) begin
                    cmd.load_out = 1'b1;
                    state_next   = fmbq_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = fmbq_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/fmbq_dp.sv =====
// Datapath: two circular half-deques in one RAM, their pointers and the result register.
module fmbq_dp (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  fmbq_pkg::dp_cmd_t               cmd,
    output fmbq_pkg::dp_stat_t              stat,
    input  logic [fmbq_pkg::VALUE_W-1:0]    in_value,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [fmbq_pkg::M_TDATA_W-1:0]  m_tdata
);

    localparam int PW = fmbq_pkg::PTR_W;
    localparam int CW = fmbq_pkg::CNT_W;
    localparam int DW = fmbq_pkg::DATA_WIDTH;

    logic [PW-1:0] hf_reg, hf_next, hb_reg, hb_next;
    logic [CW-1:0] nf_reg, nf_next, nb_reg, nb_next;
    logic [DW-1:0] value_reg;
    logic [DW-1:0] data_reg;
    logic [fmbq_pkg::STATUS_W-1:0] status_reg;
    logic          m_tvalid_reg;
    logic [fmbq_pkg::M_TDATA_W-1:0] m_tdata_reg;

    logic [PW-1:0] h_sel, n_low, addr;
    logic [CW-1:0] count;
    logic [DW-1:0] rdata, wdata;

    assign h_sel = cmd.half ? hb_reg : hf_reg;
    assign n_low = cmd.half ? nb_reg[PW-1:0] : nf_reg[PW-1:0];
    assign count = nf_reg + nb_reg;

    always_comb begin
        if (cmd.push) begin
            addr = cmd.tail ? h_sel + n_low : h_sel - PW'(1);
        end else begin
            addr = cmd.tail ? h_sel + n_low - PW'(1) : h_sel;
        end
    end

    assign wdata = cmd.from_ram ? rdata : value_reg;

    fmbq_ram #(
        .WIDTH(DW),
        .DEPTH(fmbq_pkg::RAM_DEPTH)
    ) u_ram (
        .aclk (aclk),
        .we   (cmd.push),
        .waddr({cmd.half, addr}),
        .wdata(wdata),
        .re   (cmd.pop),
        .raddr({cmd.half, addr}),
        .rdata(rdata)
    );

    always_comb begin
        hf_next = hf_reg;
        hb_next = hb_reg;
        nf_next = nf_reg;
        nb_next = nb_reg;
        if (cmd.push || cmd.pop) begin
            if (cmd.half == fmbq_pkg::HALF_FRONT) begin
                nf_next = cmd.push ? nf_reg + CW'(1) : nf_reg - CW'(1);
                if (!cmd.tail) begin
                    hf_next = cmd.push ? hf_reg - PW'(1) : hf_reg + PW'(1);
                end
            end else begin
                nb_next = cmd.push ? nb_reg + CW'(1) : nb_reg - CW'(1);
                if (!cmd.tail) begin
                    hb_next = cmd.push ? hb_reg - PW'(1) : hb_reg + PW'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hf_reg       <= '0;
            hb_reg       <= '0;
            nf_reg       <= '0;
            nb_reg       <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            hf_reg <= hf_next;
            hb_reg <= hb_next;
            nf_reg <= nf_next;
            nb_reg <= nb_next;
            if (cmd.load_out) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
        if (cmd.accept) begin
            value_reg  <= in_value[DW-1:0];
            data_reg   <= '0;
            status_reg <= fmbq_pkg::ST_OK;
        end else begin
            if (cmd.cap_data) begin
                data_reg <= rdata;
            end
            if (cmd.set_status) begin
                status_reg <= cmd.status;
            end
        end
        if (cmd.load_out) begin
            m_tdata_reg <= {3'b000, fmbq_pkg::OCC_W'(count), status_reg,
                            fmbq_pkg::DATA_W'(data_reg)};
        end
    end

    assign stat.empty       = (count == '0);
    assign stat.full        = (count >= CW'(fmbq_pkg::DEPTH));
    assign stat.odd         = count[0];
    assign stat.front_empty = (nf_reg == '0);
    assign stat.b2f         = (nb_reg > nf_reg + CW'(1));
    assign stat.f2b         = (nf_reg > nb_reg);
    assign stat.out_busy    = m_tvalid_reg && !m_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// ===== rtl/front_middle_back_queue_core.sv =====
// Top level of the front/middle/back queue: sequencer plus datapath.
//
//  channel | direction | tdata fields (lowest bit up)
//  s_      | in        | action[2:0], value[34:3], zero fill to 40 bits
//  m_      | out       | data[31:0], status[33:32], occupancy[44:34], zero fill to 48
//
// Each item passes through accept, access, an optional read-data step for
// pops, a balance check, an optional move of one word between the two
// half-deques, and the result load; the single RAM port pair sets this.
// A dropped push, a pop on an empty queue or an unused code skips the
// balance check.
// Reset clears the counts and pointers; stored words need no clearing.
// A stalled result beat holds the sequencer in its last state; the next item
// is taken while a finished result still waits.
module front_middle_back_queue_core (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [fmbq_pkg::S_TDATA_W-1:0]  s_tdata,  // action, value
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [fmbq_pkg::M_TDATA_W-1:0]  m_tdata   // data, status, occupancy
);

    fmbq_pkg::dp_cmd_t  cmd;
    fmbq_pkg::dp_stat_t stat;

    fmbq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .in_action(s_tdata[fmbq_pkg::ACTION_W-1:0]),
        .stat     (stat),
        .cmd      (cmd)
    );

    fmbq_dp u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .stat    (stat),
        .in_value(s_tdata[fmbq_pkg::ACTION_W +: fmbq_pkg::VALUE_W]),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

endmodule

// ===== rtl/fmbq_checker.sv =====
// Port-level checks of the queue's result beats.
module fmbq_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [fmbq_pkg::M_TDATA_W-1:0]  m_tdata
);

    logic [1:0]  st;
    logic [10:0] occ;

    assign st  = m_tdata[33:32];
    assign occ = m_tdata[44:34];

    a_occ_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> occ <= 11'(fmbq_pkg::DEPTH))
        else $error("occupancy above depth");

    a_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && st == fmbq_pkg::ST_EMPTY |-> occ == '0 && m_tdata[31:0] == '0)
        else $error("empty status with words stored or data");

    a_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && st == fmbq_pkg::ST_FULL |-> occ == 11'(fmbq_pkg::DEPTH))
        else $error("full status below depth");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result beat changed");

endmodule

bind front_middle_back_queue_core fmbq_checker u_fmbq_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
);
